### design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Implication checks that compile away when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("implication check failed");
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons)
`define ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

### design/ndcv_pkg.sv
// ---------------------------------------------------------------------------
// ndcv_pkg
// Shared types, register indexes and constants of the neighbour test.
// ---------------------------------------------------------------------------
`default_nettype none
package ndcv_pkg;

    localparam int NUM_AGENTS_DEF = 9;
    localparam int ANGLE_BITS_DEF = 16;

    localparam int ID_W    = 4;
    localparam int POS_W   = 16;
    localparam int KIND_W  = 2;
    localparam int DEG_W   = 4;
    localparam int RAD_W   = 15;
    localparam int CFG_I_W = 1;

    localparam logic [CFG_I_W-1:0] CFG_SELF_ID     = 1'b0;
    localparam logic [CFG_I_W-1:0] CFG_COMM_RADIUS = 1'b1;

    localparam logic [ID_W-1:0]   SELF_ID_RST = 4'd0;
    localparam logic [RAD_W-1:0]  RADIUS_RST  = 15'd1024;

    localparam logic [KIND_W-1:0] KIND_MISSION = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SCOUT   = 2'd3;

    // arctangent of 2^-i in units of 2^32 per turn
    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef enum logic [3:0] {
        OP_NONE, OP_R2, OP_RD, OP_SQX, OP_SQY, OP_CMP, OP_NEXT, OP_CINIT,
        OP_CITER, OP_INS, OP_GINIT, OP_GSQX, OP_GSQY, OP_GCMP, OP_OUT
    } ndcv_op_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_R2, ST_RD, ST_SQX, ST_SQY, ST_CMP, ST_NEXT, ST_CINIT,
        ST_CITER, ST_INS, ST_GINIT, ST_GSQX, ST_GSQY, ST_GCMP, ST_DONE
    } ndcv_state_t;

    typedef struct packed {
        ndcv_op_t op;
    } ndcv_cmd_t;

    typedef struct packed {
        logic own_hit;
        logic take_bearing;
        logic j_last;
        logic iter_last;
        logic n_zero;
        logic gap_last;
        logic out_busy;
    } ndcv_stat_t;

endpackage
`default_nettype wire

### design/ndcv_if.sv
// ---------------------------------------------------------------------------
// ndcv_if
// Valid/ready channels for agent updates and test results.
// ---------------------------------------------------------------------------
`default_nettype none
interface ndcv_in_if
    import ndcv_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   agent_id;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [KIND_W-1:0] agent_kind;

    modport source (output valid, agent_id, pos_x, pos_y, agent_kind, input ready);
    modport sink   (input valid, agent_id, pos_x, pos_y, agent_kind, output ready);
endinterface

interface ndcv_out_if
    import ndcv_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [DEG_W-1:0] degree;
    logic             is_cut_vertex;

    modport source (output valid, degree, is_cut_vertex, input ready);
    modport sink   (input valid, degree, is_cut_vertex, output ready);
endinterface
`default_nettype wire

### design/neighbor_degree_and_cut_vertex_test.sv
// ---------------------------------------------------------------------------
// neighbor_degree_and_cut_vertex_test
// Degree count and cut-vertex flag for the own agent of a robot team.
// ---------------------------------------------------------------------------
// An update for another agent is stored in the table and gives no result; an
// update with agent_id at or above NUM_AGENTS is dropped. An update for the
// own agent (agent_id equal to self_id) starts a scan and gives one result.
// The scan visits every table entry through one shared 17x17 squarer, runs
// the 32-step CORDIC and an insert for each mission neighbour in range, then
// checks each gap between neighbouring bearings. No new update is taken until
// the scan ends and its result has been loaded. A finished result waits in an
// output register, so a stalled result does not hold up other-agent updates.
// Configuration writes are meant for idle periods.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module neighbor_degree_and_cut_vertex_test
    import ndcv_pkg::*;
#(
    parameter int NUM_AGENTS = NUM_AGENTS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    ndcv_in_if.sink                 in,
    ndcv_out_if.source              out,
    input  wire logic               cfg_we,
    input  wire logic [CFG_I_W-1:0] cfg_index,
    input  wire logic [RAD_W-1:0]   cfg_wdata
);

    ndcv_cmd_t  cmd;
    ndcv_stat_t stat;
    logic       in_ready;
    logic       in_fire;

    // an update transfer happens only while the sequencer is idle
    assign in.ready = in_ready;
    assign in_fire  = in.valid && in_ready;

    ndcv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .stat     (stat),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    ndcv_datapath #(
        .NUM_AGENTS (NUM_AGENTS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .agent_id   (in.agent_id),
        .pos_x      (in.pos_x),
        .pos_y      (in.pos_y),
        .agent_kind (in.agent_kind),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (out.valid),
        .out_ready  (out.ready),
        .out_degree (out.degree),
        .out_cut    (out.is_cut_vertex)
    );

    // a result load always shows up as a valid result on the next cycle
    `ASSERT_NEXT(a_load_shows, clk, rst_n, cmd.op == OP_OUT, out.valid)
    // no update is taken while the bearing unit iterates
    `ASSERT_IMPLY(a_busy_no_take, clk, rst_n, cmd.op == OP_CITER, !in.ready)
    // the degree never counts more neighbours than there are other agents
    `ASSERT_IMPLY(a_deg_bound, clk, rst_n, out.valid, int'(out.degree) < NUM_AGENTS)

endmodule
`default_nettype wire

### design/ndcv_datapath.sv
// ---------------------------------------------------------------------------
// ndcv_datapath
// Position tables, shared squarer, CORDIC bearing unit, sorted lanes.
// ---------------------------------------------------------------------------
`default_nettype none
module ndcv_datapath
    import ndcv_pkg::*;
#(
    parameter int NUM_AGENTS = NUM_AGENTS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_fire,
    input  wire logic [ID_W-1:0]         agent_id,
    input  wire logic signed [POS_W-1:0] pos_x,
    input  wire logic signed [POS_W-1:0] pos_y,
    input  wire logic [KIND_W-1:0]       agent_kind,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_I_W-1:0]      cfg_index,
    input  wire logic [RAD_W-1:0]        cfg_wdata,
    input  wire ndcv_cmd_t               cmd,
    output ndcv_stat_t                   stat,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [DEG_W-1:0]             out_degree,
    output logic                         out_cut
);

    localparam int IDX_W = (NUM_AGENTS > 1) ? $clog2(NUM_AGENTS) : 1;
    localparam int CNT_W = $clog2(NUM_AGENTS + 1);
    localparam int DW    = POS_W + 1;
    localparam int CW    = DW + 18;
    localparam int AB    = ANGLE_BITS;
    localparam logic [31:0]   RND  = 32'd1 << (31 - AB);
    localparam logic [AB:0]   HALF = (AB+1)'(1) << (AB - 1);

    // configuration
    logic [ID_W-1:0]  self_reg;
    logic [RAD_W-1:0] rad_reg;

    // agent tables
    logic signed [POS_W-1:0] x_tab_reg [NUM_AGENTS];
    logic signed [POS_W-1:0] y_tab_reg [NUM_AGENTS];
    logic [KIND_W-1:0]       k_tab_reg [NUM_AGENTS];

    logic signed [POS_W-1:0] ox_reg, oy_reg;
    logic [IDX_W-1:0]        j_reg;
    logic signed [DW-1:0]    dx_reg, dy_reg;
    logic [KIND_W-1:0]       kind_reg;
    logic                    skip_reg;
    logic [29:0]             r2_reg;
    logic [33:0]             acc_reg;
    logic [DEG_W-1:0]        deg_reg;
    logic [1:0]              empty_reg;

    // CORDIC
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic [31:0]          cz_reg;
    logic [4:0]           ci_reg;
    logic                 zero_reg;

    // sorted neighbour lanes
    logic [AB-1:0]        lb_reg  [NUM_AGENTS];
    logic signed [DW-1:0] ldx_reg [NUM_AGENTS];
    logic signed [DW-1:0] ldy_reg [NUM_AGENTS];
    logic [CNT_W-1:0]     n_reg, gk_reg;
    logic [AB-1:0]        fb_reg;
    logic signed [DW-1:0] fdx_reg, fdy_reg;

    logic                 out_valid_reg;
    logic [DEG_W-1:0]     out_deg_reg;
    logic                 out_cut_reg;

    logic                 own_hit, in_range, gap_last;
    logic signed [DW-1:0] m_op, s_dx, s_dy;
    logic signed [2*DW-1:0] m_prod;
    logic signed [CW-1:0] xs, ys, cx_in, cy_in;
    logic [31:0]          z_rnd;
    logic [AB-1:0]        b_new;
    logic [AB:0]          s_b, gap;
    logic [NUM_AGENTS-1:0] sh;

    assign own_hit  = (int'(agent_id) < NUM_AGENTS) && (agent_id == self_reg);
    assign in_range = !skip_reg && (acc_reg < {4'd0, r2_reg});
    assign gap_last = (gk_reg == n_reg - CNT_W'(1));

    assign s_dx = gap_last ? fdx_reg : ldx_reg[1];
    assign s_dy = gap_last ? fdy_reg : ldy_reg[1];
    assign s_b  = gap_last ? {1'b1, fb_reg} : {1'b0, lb_reg[1]};
    assign gap  = s_b - {1'b0, lb_reg[0]};

    // shared squarer
    always_comb
    begin
        case (cmd.op)
            OP_R2:   m_op = {2'b00, rad_reg};
            OP_SQX:  m_op = dx_reg;
            OP_SQY:  m_op = dy_reg;
            OP_GSQX: m_op = s_dx - ldx_reg[0];
            OP_GSQY: m_op = s_dy - ldy_reg[0];
            default: m_op = '0;
        endcase
    end
    assign m_prod = m_op * m_op;

    assign xs    = cx_reg >>> ci_reg;
    assign ys    = cy_reg >>> ci_reg;
    assign cx_in = {{4{dx_reg[DW-1]}}, dx_reg, 14'd0};
    assign cy_in = {{4{dy_reg[DW-1]}}, dy_reg, 14'd0};
    assign z_rnd = cz_reg + RND;
    assign b_new = zero_reg ? '0 : z_rnd[31 -: AB];

    always_comb
    begin
        for (int e = 0; e < NUM_AGENTS; e++)
        begin
            sh[e] = (e < int'(n_reg)) && (lb_reg[e] > b_new);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_reg <= SELF_ID_RST;
            rad_reg  <= RADIUS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SELF_ID:     self_reg <= cfg_wdata[ID_W-1:0];
                CFG_COMM_RADIUS: rad_reg  <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < NUM_AGENTS; e++)
            begin
                x_tab_reg[e] <= '0;
                y_tab_reg[e] <= '0;
                k_tab_reg[e] <= '0;
            end
        end
        else if (in_fire)
        begin
            for (int e = 0; e < NUM_AGENTS; e++)
            begin
                if (int'(agent_id) == e)
                begin
                    x_tab_reg[e] <= pos_x;
                    y_tab_reg[e] <= pos_y;
                    if (agent_id != self_reg)
                    begin
                        k_tab_reg[e] <= agent_kind;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == OP_OUT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && own_hit)
        begin
            ox_reg    <= pos_x;
            oy_reg    <= pos_y;
            j_reg     <= '0;
            n_reg     <= '0;
            deg_reg   <= '0;
            empty_reg <= '0;
        end
        case (cmd.op)
            OP_R2: r2_reg <= m_prod[29:0];
            OP_RD:
            begin
                dx_reg   <= {x_tab_reg[j_reg][POS_W-1], x_tab_reg[j_reg]}
                            - {ox_reg[POS_W-1], ox_reg};
                dy_reg   <= {y_tab_reg[j_reg][POS_W-1], y_tab_reg[j_reg]}
                            - {oy_reg[POS_W-1], oy_reg};
                kind_reg <= k_tab_reg[j_reg];
                skip_reg <= (int'(j_reg) == int'(self_reg));
            end
            OP_SQX, OP_GSQX: acc_reg <= $unsigned(m_prod);
            OP_SQY, OP_GSQY: acc_reg <= acc_reg + $unsigned(m_prod);
            OP_CMP:
            begin
                if (in_range && (kind_reg == KIND_MISSION || kind_reg == KIND_SCOUT)
                    && deg_reg != '1)
                begin
                    deg_reg <= deg_reg + DEG_W'(1);
                end
            end
            OP_NEXT: j_reg <= j_reg + IDX_W'(1);
            OP_CINIT:
            begin
                zero_reg <= (dx_reg == '0) && (dy_reg == '0);
                ci_reg   <= '0;
                if (dx_reg[DW-1])
                begin
                    cx_reg <= -cx_in;
                    cy_reg <= -cy_in;
                    cz_reg <= 32'h8000_0000;
                end
                else
                begin
                    cx_reg <= cx_in;
                    cy_reg <= cy_in;
                    cz_reg <= '0;
                end
            end
            OP_CITER:
            begin
                ci_reg <= ci_reg + 5'd1;
                if (cy_reg[CW-1])
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - ATAN_TURNS[ci_reg];
                end
                else
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + ATAN_TURNS[ci_reg];
                end
            end
            OP_INS:
            begin
                // stable insert: lanes above the new bearing move up one place
                for (int e = 0; e < NUM_AGENTS; e++)
                begin
                    if (e > 0 && sh[(e > 0) ? e - 1 : 0])
                    begin
                        lb_reg[e]  <= lb_reg[(e > 0) ? e - 1 : 0];
                        ldx_reg[e] <= ldx_reg[(e > 0) ? e - 1 : 0];
                        ldy_reg[e] <= ldy_reg[(e > 0) ? e - 1 : 0];
                    end
                    else if (e == int'(n_reg) || sh[e])
                    begin
                        lb_reg[e]  <= b_new;
                        ldx_reg[e] <= dx_reg;
                        ldy_reg[e] <= dy_reg;
                    end
                end
                n_reg <= n_reg + CNT_W'(1);
            end
            OP_GINIT:
            begin
                fb_reg  <= lb_reg[0];
                fdx_reg <= ldx_reg[0];
                fdy_reg <= ldy_reg[0];
                gk_reg  <= '0;
            end
            OP_GCMP:
            begin
                if ((gap >= HALF || acc_reg > {4'd0, r2_reg}) && empty_reg != 2'd2)
                begin
                    empty_reg <= empty_reg + 2'd1;
                end
                for (int e = 0; e < NUM_AGENTS - 1; e++)
                begin
                    lb_reg[e]  <= lb_reg[e+1];
                    ldx_reg[e] <= ldx_reg[e+1];
                    ldy_reg[e] <= ldy_reg[e+1];
                end
                gk_reg <= gk_reg + CNT_W'(1);
            end
            OP_OUT:
            begin
                out_deg_reg <= deg_reg;
                out_cut_reg <= empty_reg[1];
            end
            default: ;
        endcase
    end

    assign stat.own_hit      = own_hit;
    assign stat.take_bearing = in_range && (kind_reg == KIND_MISSION);
    assign stat.j_last       = (int'(j_reg) == NUM_AGENTS - 1);
    assign stat.iter_last    = (ci_reg == 5'd31);
    assign stat.n_zero       = (n_reg == '0);
    assign stat.gap_last     = gap_last;
    assign stat.out_busy     = out_valid_reg && !out_ready;

    assign out_valid  = out_valid_reg;
    assign out_degree = out_deg_reg;
    assign out_cut    = out_cut_reg;

endmodule
`default_nettype wire

### design/ndcv_ctrl.sv
// ---------------------------------------------------------------------------
// ndcv_ctrl
// Sequencer for the distance scan, bearing, insertion and gap passes.
// ---------------------------------------------------------------------------
`default_nettype none
module ndcv_ctrl
    import ndcv_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_fire,
    input  wire ndcv_stat_t stat,
    output ndcv_cmd_t       cmd,
    output logic            in_ready
);

    ndcv_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_fire && stat.own_hit) state_next = ST_R2;
            ST_R2:    state_next = ST_RD;
            ST_RD:    state_next = ST_SQX;
            ST_SQX:   state_next = ST_SQY;
            ST_SQY:   state_next = ST_CMP;
            ST_CMP:
            begin
                if (stat.take_bearing)
                begin
                    state_next = ST_CINIT;
                end
                else if (stat.j_last)
                begin
                    state_next = ST_GINIT;
                end
                else
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:  state_next = ST_RD;
            ST_CINIT: state_next = ST_CITER;
            ST_CITER: if (stat.iter_last) state_next = ST_INS;
            ST_INS:   state_next = stat.j_last ? ST_GINIT : ST_NEXT;
            ST_GINIT: state_next = stat.n_zero ? ST_DONE : ST_GSQX;
            ST_GSQX:  state_next = ST_GSQY;
            ST_GSQY:  state_next = ST_GCMP;
            ST_GCMP:  state_next = stat.gap_last ? ST_DONE : ST_GSQX;
            ST_DONE:  if (!stat.out_busy) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        case (state_reg)
            ST_R2:    cmd.op = OP_R2;
            ST_RD:    cmd.op = OP_RD;
            ST_SQX:   cmd.op = OP_SQX;
            ST_SQY:   cmd.op = OP_SQY;
            ST_CMP:   cmd.op = OP_CMP;
            ST_NEXT:  cmd.op = OP_NEXT;
            ST_CINIT: cmd.op = OP_CINIT;
            ST_CITER: cmd.op = OP_CITER;
            ST_INS:   cmd.op = OP_INS;
            ST_GINIT: cmd.op = OP_GINIT;
            ST_GSQX:  cmd.op = OP_GSQX;
            ST_GSQY:  cmd.op = OP_GSQY;
            ST_GCMP:  cmd.op = OP_GCMP;
            ST_DONE:  cmd.op = stat.out_busy ? OP_NONE : OP_OUT;
            default:  cmd.op = OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

### sim/ndcv_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ndcv_checker
// Watches the update, result and register ports of the neighbour test, works
// out the degree and cut-vertex flag of every own update and compares them.
// ----------------------------------------------------------------------------
module ndcv_checker
    import ndcv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    ndcv_in_if                 in_ch,
    ndcv_out_if                out_ch,
    input  logic               cfg_we,
    input  logic [CFG_I_W-1:0] cfg_index,
    input  logic [RAD_W-1:0]   cfg_wdata,
    output int                 fail_count,
    output int                 pending,
    output int                 result_count
);

    localparam int AGENTS = NUM_AGENTS_DEF;

    typedef struct packed {
        logic [DEG_W-1:0] degree;
        logic             cut;
    } verdict_t;

    logic [ID_W-1:0]         own_id;
    logic [RAD_W-1:0]        radius;
    logic signed [POS_W-1:0] px [AGENTS];
    logic signed [POS_W-1:0] py [AGENTS];
    logic [KIND_W-1:0]       role [AGENTS];
    verdict_t                awaited [$];

    assign pending = awaited.size();

    function automatic longint sq_dist(int p, int q);
        longint dx;
        longint dy;
        dx = longint'(px[p]) - longint'(px[q]);
        dy = longint'(py[p]) - longint'(py[q]);
        return dx * dx + dy * dy;
    endfunction

    // vectoring CORDIC, 2^32 units per turn, rounded to 16 bits
    function automatic int bearing(longint dx, longint dy);
        longint      x;
        longint      y;
        longint      xs;
        longint      ys;
        logic [31:0] z;
        if (dx == 0 && dy == 0)
            return 0;
        x = dx * 16384;
        y = dy * 16384;
        z = '0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < 32; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y < 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_TURNS[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_TURNS[i];
            end
        end
        z = z + 32'h0000_8000;
        return int'(z[31:16]);
    endfunction

    function automatic verdict_t neighbour_verdict(int me);
        longint   r2;
        int       deg;
        int       n;
        int       empty;
        int       b;
        int       k;
        int       brg [AGENTS + 1];
        int       ids [AGENTS + 1];
        verdict_t v;
        r2 = longint'(radius) * longint'(radius);
        deg = 0;
        n = 0;
        empty = 0;
        for (int j = 0; j < AGENTS; j++)
        begin
            if (j == me || sq_dist(me, j) >= r2)
                continue;
            if (role[j] == KIND_MISSION || role[j] == KIND_SCOUT)
                deg++;
            if (role[j] == KIND_MISSION)
            begin
                b = bearing(longint'(px[j]) - longint'(px[me]),
                            longint'(py[j]) - longint'(py[me]));
                k = n;
                // insertion sort, ties keep table order
                while (k > 0 && b < brg[k - 1])
                begin
                    brg[k] = brg[k - 1];
                    ids[k] = ids[k - 1];
                    k--;
                end
                brg[k] = b;
                ids[k] = j;
                n++;
            end
        end
        if (n > 0)
        begin
            brg[n] = brg[0] + 65536;
            ids[n] = ids[0];
            for (k = 0; k < n; k++)
                if (brg[k + 1] - brg[k] >= 32768 || sq_dist(ids[k], ids[k + 1]) > r2)
                    empty++;
        end
        v.degree = (deg > 15) ? 4'd15 : DEG_W'(deg);
        v.cut = (empty > 1);
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            own_id = SELF_ID_RST;
            radius = RADIUS_RST;
            for (int i = 0; i < AGENTS; i++)
            begin
                px[i] = '0;
                py[i] = '0;
                role[i] = '0;
            end
            awaited.delete();
            fail_count = 0;
            result_count = 0;
        end
        else
        begin
            // results first: a result cannot stem from an update of this edge
            if (out_ch.valid && out_ch.ready)
            begin
                result_count++;
                if (awaited.size() == 0)
                begin
                    $error("result transfer with nothing awaited: degree %0d cut %0b",
                           out_ch.degree, out_ch.is_cut_vertex);
                    fail_count++;
                end
                else
                begin
                    want = awaited.pop_front();
                    if (out_ch.degree !== want.degree)
                    begin
                        $error("degree: expected %0d, got %0d", want.degree, out_ch.degree);
                        fail_count++;
                    end
                    if (out_ch.is_cut_vertex !== want.cut)
                    begin
                        $error("is_cut_vertex: expected %0b, got %0b",
                               want.cut, out_ch.is_cut_vertex);
                        fail_count++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready && in_ch.agent_id < AGENTS)
            begin
                px[in_ch.agent_id] = in_ch.pos_x;
                py[in_ch.agent_id] = in_ch.pos_y;
                if (in_ch.agent_id != own_id)
                    role[in_ch.agent_id] = in_ch.agent_kind;
                else
                    awaited.insert(awaited.size(),
                                   neighbour_verdict(int'(in_ch.agent_id)));
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_SELF_ID)
                    own_id = cfg_wdata[ID_W-1:0];
                else if (cfg_index == CFG_COMM_RADIUS)
                    radius = cfg_wdata;
            end
        end
    end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the neighbour degree and cut-vertex test. A short
// directed run covers coincident, tied, far and out-of-range agents; random
// clusters of agents around the own position follow under several register
// settings and idling patterns. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb;
    import ndcv_pkg::*;

    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELAY = 2'd2;
    localparam int LIMIT_CYCLES = 5_000_000;
    localparam int SCAN_CYCLES  = 400;  // worst-case own scan plus hand-off

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [CFG_I_W-1:0] cfg_index;
    logic [RAD_W-1:0]   cfg_wdata;

    ndcv_in_if  in_ch ();
    ndcv_out_if out_ch ();

    int fail_count;
    int pending;
    int result_count;
    int item_count;
    int cycle_count;
    int idle_pct;
    int stall_pct;
    logic hold_off;
    logic hold_go;

    // shadow of the registers for stimulus shaping only
    int own_id;
    int radius;
    int cx;
    int cy;

    neighbor_degree_and_cut_vertex_test dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in        (in_ch),
        .out       (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    ndcv_checker scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // abandon the run if it never drains
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    // result side: stall at random, or hold off completely while asked
    always @(negedge clk)
        out_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);

    // long receiver hold-off, counted here so the sender keeps going meanwhile
    initial
    begin
        hold_off = 1'b0;
        @(posedge hold_go);
        hold_off = 1'b1;
        repeat (1500) @(negedge clk);
        hold_off = 1'b0;
    end

    // one transfer on the update channel; starts and ends at a falling edge
    task automatic send(input int id, input int x, input int y, input logic [1:0] kind);
        while ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.agent_id   <= ID_W'(id);
        in_ch.pos_x      <= POS_W'(x);
        in_ch.pos_y      <= POS_W'(y);
        in_ch.agent_kind <= kind;
        do
            @(posedge clk);
        while (!(in_ch.valid && in_ch.ready));
        item_count++;
        @(negedge clk);
    endtask

    // drop valid and wait until the last scan has surely finished
    task automatic drain;
        in_ch.valid <= 1'b0;
        @(negedge clk);
        wait (pending == 0);
        @(negedge clk);
        repeat (SCAN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_I_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= RAD_W'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(input int id, input int rad);
        write_reg(CFG_SELF_ID, id);
        write_reg(CFG_COMM_RADIUS, rad);
        own_id = id;
        radius = rad;
    endtask

    function automatic int clip16(input int v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    // position near the cluster centre, within about twice the radius
    function automatic int near(input int c);
        int span;
        span = 2 * radius + 16;
        if (span > 32767)
            span = 32767;
        return clip16(c + $urandom_range(2 * span) - span);
    endfunction

    task automatic random_update;
        int r;
        r = $urandom_range(99);
        if (r < 20)
            send(own_id, near(cx), near(cy), 2'($urandom_range(3)));
        else if (r < 85)
            send($urandom_range(NUM_AGENTS_DEF - 1), near(cx), near(cy),
                 2'($urandom_range(3)));
        else if (r < 93)
            send($urandom_range(15), $urandom_range(65535) - 32768,
                 $urandom_range(65535) - 32768, 2'($urandom_range(3)));
        else
            send($urandom_range(15, NUM_AGENTS_DEF), $urandom_range(65535) - 32768,
                 $urandom_range(65535) - 32768, 2'($urandom_range(3)));
    endtask

    initial
    begin
        int seg_self [8];
        int seg_rad [8];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.agent_id = '0;
        in_ch.pos_x = '0;
        in_ch.pos_y = '0;
        in_ch.agent_kind = '0;
        out_ch.ready = 1'b0;
        hold_go = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        item_count = 0;
        cycle_count = 0;
        own_id = SELF_ID_RST;
        radius = RADIUS_RST;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset registers (own agent 0, radius 4 m)
        send(0, 0, 0, KIND_NONE);                   // empty table: degree zero
        send(1, 0, 0, KIND_MISSION);                // coincident neighbour
        send(0, 0, 0, KIND_NONE);                   // single mission neighbour
        send(2, 512, 0, KIND_SCOUT);
        send(3, 0, -512, KIND_MISSION);
        send(4, -32768, 32767, KIND_MISSION);       // far outside the radius
        send(5, 100, 100, KIND_RELAY);              // relay not counted
        send(0, 0, 0, KIND_SCOUT);                  // own role ignored
        send(6, 1000, 0, KIND_MISSION);
        send(7, -1000, 0, KIND_MISSION);            // pair farther apart than radius
        send(8, 300, 0, KIND_MISSION);              // same bearing as agent 6
        send(0, 0, 0, KIND_NONE);
        send(9, 1, 1, KIND_MISSION);                // index out of range
        send(15, -1, -1, KIND_SCOUT);
        send(12, 32767, -32768, KIND_MISSION);
        send(0, 32767, -32768, KIND_NONE);          // own at the extreme corner
        send(0, -32768, 32767, KIND_MISSION);
        send(4, -32700, 32700, KIND_SCOUT);
        send(0, -32768, 32767, KIND_NONE);
        drain();

        // segments of random clusters; each setting applied on an idle block
        seg_self = '{8, 0, 4, 8, 2, 0, 7, 5};
        seg_rad  = '{32767, 0, 1024, 2000, 600, 4000, 1, 1500};
        for (int seg = 0; seg < 8; seg++)
        begin
            configure(seg_self[seg], (seg >= 6 && seg_rad[seg] > 1)
                      ? $urandom_range(3000, 200) : seg_rad[seg]);
            case (seg % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 47; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 47; end
                default: begin idle_pct = 8; stall_pct = 8; end
            endcase
            cx = $urandom_range(40000) - 20000;
            cy = $urandom_range(40000) - 20000;
            for (int i = 0; i < 235; i++)
            begin
                if (seg == 2 && i == 20)
                    hold_go = 1'b1;                 // fill the block behind a held result
                // pause now and then until every result is home
                if (i == 120 && seg % 2 == 1)
                begin
                    in_ch.valid <= 1'b0;
                    @(negedge clk);
                    wait (pending == 0);
                    @(negedge clk);
                end
                random_update();
            end
            drain();
        end

        $display("covered %0d updates and %0d results over eight register settings,",
                 item_count, result_count);
        $display("with sender gaps, receiver stalls and a long result hold-off");
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/ndcv_pkg.sv
design/ndcv_if.sv
design/ndcv_datapath.sv
design/ndcv_ctrl.sv
design/neighbor_degree_and_cut_vertex_test.sv
sim/ndcv_checker.sv
sim/tb.sv
